// ===== rtl/core/wlgs_pkg.sv =====
// Shared types and constants for the weighted Laplacian Gauss-Seidel solver.
// Used by the controller, the datapath and the top level.
`default_nettype none

package wlgs_pkg;

  // Default store sizes.
  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned MaxEdgesDef    = 8192;

  // Reset values of the configuration registers.
  localparam logic [15:0] MaxIterReset = 16'd5000;
  localparam logic [30:0] TolReset     = 31'd1;

  // Configuration register indexes.
  localparam logic CfgMaxIter = 1'b0;
  localparam logic CfgTol     = 1'b1;

  // Result kinds.
  localparam logic KindStatus = 1'b0;
  localparam logic KindRead   = 1'b1;

  // Number of quotient bits the divider produces, one per cycle.
  localparam int unsigned DivBits = 64;

  typedef enum logic [1:0] {
    OP_LOAD_V = 2'd0,
    OP_LOAD_E = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_OUT_RD,
    DP_OUT_ST,
    DP_SWEEP_INIT,
    DP_V_FETCH,
    DP_V_CHK,
    DP_E_READ,
    DP_E_SKIP,
    DP_E_TGT,
    DP_E_MUL,
    DP_E_ACC,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_V_WB,
    DP_V_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sw_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic iter_zero;
    logic count_zero;
    logic v_skip;
    logic edge_end;
    logic tgt_oob;
    logic div_last;
    logic v_last;
    logic conv_hit;
    logic iter_last;
  } status_t;

  // Per-vertex metadata word.
  typedef struct packed {
    logic        pinned;
    logic [31:0] wt;
    logic [12:0] start;
    logic [13:0] len;
  } vmeta_t;

  // Per-edge word.
  typedef struct packed {
    logic [9:0]  target;
    logic [31:0] weight;
  } edge_t;

endpackage

`default_nettype wire

// ===== rtl/core/wlgs_in_if.sv =====
// Input channel of the solver: valid/ready handshake and the item fields.
// Depends on nothing.
`default_nettype none

interface wlgs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [12:0] slot;
  logic [31:0] value;
  logic [31:0] weight;
  logic        pinned;
  logic [12:0] first_edge;
  logic [13:0] edge_count;
  logic [9:0]  neighbour;
  logic [10:0] vertex_count;

  modport source (output valid, opcode, slot, value, weight, pinned, first_edge,
                  edge_count, neighbour, vertex_count, input ready);
  modport sink (input valid, opcode, slot, value, weight, pinned, first_edge,
                edge_count, neighbour, vertex_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wlgs_out_if.sv =====
// Result channel of the solver: valid/ready handshake and the result fields.
// Depends on nothing.
`default_nettype none

interface wlgs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] result_value;
  logic [15:0] sweeps_done;
  logic        converged;

  modport source (output valid, kind, result_value, sweeps_done, converged,
                  input ready);
  modport sink (input valid, kind, result_value, sweeps_done, converged,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/weighted_laplacian_gauss_seidel.sv =====
// Top level of the weighted Laplacian Gauss-Seidel solver.
// Depends on wlgs_pkg, wlgs_in_if, wlgs_out_if, wlgs_ctrl and wlgs_dp.
//
//   channel   direction  handshake          beat
//   in_ch     input      valid / ready      opcode, slot, value, weight, ...
//   out_ch    output     valid / ready      kind, result_value, sweeps, conv
//   cfg_*     input      cfg_we only        cfg_index, cfg_data
//
// A load is written as it is accepted; a read goes through the store's
// read register to its result register. A relaxed vertex passes fetch,
// check, its edges, the bit-serial divider and write-back, a skipped one
// only fetch and check; the divider and one vertex read port set the cost.
// Reset is synchronous (rst_n low); stores keep their contents.
// Items are taken one at a time; a finished result waits in its own register.
`default_nettype none

module weighted_laplacian_gauss_seidel #(
  parameter int unsigned MAX_VERTICES = wlgs_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = wlgs_pkg::MaxEdgesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wlgs_in_if.sink          in_ch,
  wlgs_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data
);

  wlgs_pkg::cmd_t    cmd;
  wlgs_pkg::status_t stat;

  wlgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wlgs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_ch.opcode),
    .in_slot          (in_ch.slot),
    .in_value         (in_ch.value),
    .in_weight        (in_ch.weight),
    .in_pinned        (in_ch.pinned),
    .in_first_edge    (in_ch.first_edge),
    .in_edge_count    (in_ch.edge_count),
    .in_neighbour     (in_ch.neighbour),
    .in_vertex_count  (in_ch.vertex_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_result_value (out_ch.result_value),
    .out_sweeps_done  (out_ch.sweeps_done),
    .out_converged    (out_ch.converged)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wlgs_ctrl.sv =====
// Controller state machine of the solver: sequences loads, reads and sweeps.
// Depends on wlgs_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module wlgs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_opcode,
  output logic                  in_ready,
  input  wire wlgs_pkg::status_t stat,
  output wlgs_pkg::cmd_t        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_START,
    ST_SW_BEGIN,
    ST_V_FETCH,
    ST_V_CHK,
    ST_E_READ,
    ST_E_TGT,
    ST_E_MUL,
    ST_E_ACC,
    ST_DIV,
    ST_V_WB,
    ST_V_NEXT,
    ST_SW_END,
    ST_ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and the operation for this cycle.
  always_comb begin
    state_nxt  = state_r;
    cmd.op     = wlgs_pkg::DP_NONE;
    cmd.sw_end = 1'b0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = wlgs_pkg::DP_ACCEPT;
          priority if (in_opcode == wlgs_pkg::OP_READ) state_nxt = ST_RD_OUT;
          else if (in_opcode == wlgs_pkg::OP_SOLVE) state_nxt = ST_START;
          else state_nxt = ST_IDLE;
        end
      end
      ST_RD_OUT: begin
        if (stat.out_free) begin
          cmd.op    = wlgs_pkg::DP_OUT_RD;
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        state_nxt = stat.iter_zero ? ST_ST_OUT : ST_SW_BEGIN;
      end
      ST_SW_BEGIN: begin
        cmd.op    = wlgs_pkg::DP_SWEEP_INIT;
        state_nxt = stat.count_zero ? ST_SW_END : ST_V_FETCH;
      end
      ST_V_FETCH: begin
        cmd.op    = wlgs_pkg::DP_V_FETCH;
        state_nxt = ST_V_CHK;
      end
      ST_V_CHK: begin
        cmd.op    = wlgs_pkg::DP_V_CHK;
        state_nxt = stat.v_skip ? ST_V_NEXT : ST_E_READ;
      end
      ST_E_READ: begin
        if (stat.edge_end) begin
          cmd.op    = wlgs_pkg::DP_DIV_INIT;
          state_nxt = ST_DIV;
        end else begin
          cmd.op    = wlgs_pkg::DP_E_READ;
          state_nxt = ST_E_TGT;
        end
      end
      ST_E_TGT: begin
        if (stat.tgt_oob) begin
          cmd.op    = wlgs_pkg::DP_E_SKIP;
          state_nxt = ST_E_READ;
        end else begin
          cmd.op    = wlgs_pkg::DP_E_TGT;
          state_nxt = ST_E_MUL;
        end
      end
      ST_E_MUL: begin
        cmd.op    = wlgs_pkg::DP_E_MUL;
        state_nxt = ST_E_ACC;
      end
      ST_E_ACC: begin
        cmd.op    = wlgs_pkg::DP_E_ACC;
        state_nxt = ST_E_READ;
      end
      ST_DIV: begin
        cmd.op = wlgs_pkg::DP_DIV_STEP;
        if (stat.div_last) state_nxt = ST_V_WB;
      end
      ST_V_WB: begin
        cmd.op    = wlgs_pkg::DP_V_WB;
        state_nxt = ST_V_NEXT;
      end
      ST_V_NEXT: begin
        cmd.op    = wlgs_pkg::DP_V_NEXT;
        state_nxt = stat.v_last ? ST_SW_END : ST_V_FETCH;
      end
      ST_SW_END: begin
        cmd.sw_end = 1'b1;
        state_nxt  = (stat.conv_hit || stat.iter_last) ? ST_ST_OUT : ST_SW_BEGIN;
      end
      ST_ST_OUT: begin
        if (stat.out_free) begin
          cmd.op    = wlgs_pkg::DP_OUT_ST;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wlgs_dp.sv =====
// Datapath of the solver: vertex and edge stores, multiply-accumulate,
// bit-serial divider, sweep counters, configuration and output registers.
// Depends on wlgs_pkg; controlled by wlgs_ctrl through cmd_t / status_t.
`default_nettype none

module wlgs_dp #(
  parameter int unsigned MAX_VERTICES = wlgs_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = wlgs_pkg::MaxEdgesDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wlgs_pkg::cmd_t    cmd,
  output wlgs_pkg::status_t      stat,
  // Input item fields.
  input  wire logic [1:0]        in_opcode,
  input  wire logic [12:0]       in_slot,
  input  wire logic [31:0]       in_value,
  input  wire logic [31:0]       in_weight,
  input  wire logic              in_pinned,
  input  wire logic [12:0]       in_first_edge,
  input  wire logic [13:0]       in_edge_count,
  input  wire logic [9:0]        in_neighbour,
  input  wire logic [10:0]       in_vertex_count,
  // Configuration writes.
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [30:0]       cfg_data,
  // Result register.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic [31:0]            out_result_value,
  output logic [15:0]            out_sweeps_done,
  output logic                   out_converged
);

  localparam int unsigned VA  = $clog2(MAX_VERTICES);
  localparam int unsigned VC  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VW  = (VC > 14) ? VC : 14;
  localparam int unsigned EA  = $clog2(MAX_EDGES);
  localparam int unsigned EC  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EW  = (EC > 15) ? EC : 15;
  localparam int unsigned DCW = $clog2(wlgs_pkg::DivBits + 1);

  localparam logic [VW-1:0] VLimit = VW'(MAX_VERTICES);
  localparam logic [EW-1:0] ELimit = EW'(MAX_EDGES);

  // Stores.
  logic [31:0]      val_mem  [MAX_VERTICES];
  wlgs_pkg::vmeta_t meta_mem [MAX_VERTICES];
  wlgs_pkg::edge_t  edge_mem [MAX_EDGES];

  logic [31:0]      val_rd_r;
  wlgs_pkg::vmeta_t meta_rd_r;
  wlgs_pkg::edge_t  edge_rd_r;

  // Configuration registers.
  logic [15:0] max_iter_r;
  logic [30:0] tol_r;

  // Solve state.
  logic [VW-1:0] count_r;
  logic [VW-1:0] vidx_r;
  logic [15:0]   iter_r;
  logic [31:0]   maxch_r;
  logic [15:0]   sweeps_r;
  logic          conv_r;
  logic [31:0]   old_r;
  logic [31:0]   wt_r;
  logic [13:0]   len_r;
  logic [13:0]   k_r;
  logic [EW-1:0] e_r;
  logic [31:0]   ew_r;
  logic [63:0]   prod_r;
  logic [63:0]   acc_r;
  logic          neg_r;
  logic [63:0]   dvd_r;
  logic [31:0]   rem_r;
  logic [DCW-1:0] dcnt_r;
  logic          rd_oob_r;

  // Output register.
  logic        out_valid_r;
  logic        out_kind_r;
  logic [31:0] out_value_r;
  logic [15:0] out_sweeps_r;
  logic        out_conv_r;

  // Index helpers.
  logic [VW-1:0] slot_v;
  logic [EW-1:0] slot_e;
  logic [VW-1:0] tgt_v;
  logic [VW-1:0] vc_v;
  logic [VW-1:0] vidx_inc;
  logic          acc_load_v, acc_load_e, acc_read, acc_solve;

  assign slot_v   = VW'(in_slot);
  assign slot_e   = EW'(in_slot);
  assign tgt_v    = VW'(edge_rd_r.target);
  assign vc_v     = VW'(in_vertex_count);
  assign vidx_inc = vidx_r + VW'(1);

  assign acc_load_v = (cmd.op == wlgs_pkg::DP_ACCEPT) && (in_opcode == wlgs_pkg::OP_LOAD_V);
  assign acc_load_e = (cmd.op == wlgs_pkg::DP_ACCEPT) && (in_opcode == wlgs_pkg::OP_LOAD_E);
  assign acc_read   = (cmd.op == wlgs_pkg::DP_ACCEPT) && (in_opcode == wlgs_pkg::OP_READ);
  assign acc_solve  = (cmd.op == wlgs_pkg::DP_ACCEPT) && (in_opcode == wlgs_pkg::OP_SOLVE);

  // Saturating accumulate of the registered product.
  logic [64:0] acc_sum;
  logic [63:0] acc_sat;
  always_comb begin
    acc_sum = {acc_r[63], acc_r} + {prod_r[63], prod_r};
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sat = acc_sum[63:0];
    end
  end

  // Product of edge weight (unsigned) and neighbour value (signed).
  logic signed [64:0] mul_full;
  assign mul_full = $signed({1'b0, ew_r}) * $signed(val_rd_r);

  // One restoring division step.
  logic [32:0] rem_sh;
  logic        q_bit;
  logic [32:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_r, dvd_r[63]};
    rem_sub = rem_sh - {1'b0, wt_r};
    q_bit   = (rem_sh >= {1'b0, wt_r});
  end

  // Saturated quotient and change against the old value.
  logic [31:0] q_mag;
  logic [31:0] new_val;
  logic [32:0] diff;
  logic [31:0] change;
  always_comb begin
    if (neg_r) begin
      q_mag   = (dvd_r > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : dvd_r[31:0];
      new_val = 32'd0 - q_mag;
    end else begin
      q_mag   = (dvd_r > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_r[31:0];
      new_val = q_mag;
    end
    diff   = {new_val[31], new_val} - {old_r[31], old_r};
    change = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
  end

  // Status toward the controller.
  logic [16:0] iter_inc;
  assign iter_inc = {1'b0, iter_r} + 17'd1;
  always_comb begin
    stat.out_free   = !out_valid_r || out_ready;
    stat.iter_zero  = (max_iter_r == 16'd0);
    stat.count_zero = (count_r == '0);
    stat.v_skip     = meta_rd_r.pinned || (meta_rd_r.wt == 32'd0);
    stat.edge_end   = (k_r == len_r) || (e_r >= ELimit);
    stat.tgt_oob    = (tgt_v >= VLimit);
    stat.div_last   = (dcnt_r == DCW'(1));
    stat.v_last     = (vidx_inc == count_r);
    stat.conv_hit   = (maxch_r < {1'b0, tol_r}) && (iter_r > 16'd2);
    stat.iter_last  = (iter_inc == {1'b0, max_iter_r});
  end

  // Vertex value store: one write port, one registered read port.
  logic          val_we;
  logic [VA-1:0] val_wa;
  logic [31:0]   val_wd;
  logic [VA-1:0] val_ra;
  always_comb begin
    val_we = 1'b0;
    val_wa = vidx_r[VA-1:0];
    val_wd = new_val;
    if (acc_load_v && (slot_v < VLimit)) begin
      val_we = 1'b1;
      val_wa = slot_v[VA-1:0];
      val_wd = in_value;
    end else if (cmd.op == wlgs_pkg::DP_V_WB) begin
      val_we = 1'b1;
    end
    priority if (cmd.op == wlgs_pkg::DP_E_TGT) val_ra = tgt_v[VA-1:0];
    else if (cmd.op == wlgs_pkg::DP_V_FETCH) val_ra = vidx_r[VA-1:0];
    else val_ra = slot_v[VA-1:0];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (acc_read || (cmd.op == wlgs_pkg::DP_V_FETCH) || (cmd.op == wlgs_pkg::DP_E_TGT)) begin
      val_rd_r <= val_mem[val_ra];
    end
  end

  // Vertex metadata store.
  always_ff @(posedge clk) begin
    if (acc_load_v && (slot_v < VLimit)) begin
      meta_mem[slot_v[VA-1:0]] <= '{pinned: in_pinned, wt: in_weight,
                                    start: in_first_edge, len: in_edge_count};
    end
    if (cmd.op == wlgs_pkg::DP_V_FETCH) begin
      meta_rd_r <= meta_mem[vidx_r[VA-1:0]];
    end
  end

  // Edge store.
  always_ff @(posedge clk) begin
    if (acc_load_e && (slot_e < ELimit)) begin
      edge_mem[slot_e[EA-1:0]] <= '{target: in_neighbour, weight: in_weight};
    end
    if (cmd.op == wlgs_pkg::DP_E_READ) begin
      edge_rd_r <= edge_mem[e_r[EA-1:0]];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= wlgs_pkg::MaxIterReset;
      tol_r      <= wlgs_pkg::TolReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wlgs_pkg::CfgMaxIter: max_iter_r <= cfg_data[15:0];
        wlgs_pkg::CfgTol:     tol_r      <= cfg_data;
        default:              tol_r      <= tol_r;
      endcase
    end
  end

  // Sweep, vertex and edge working registers.
  always_ff @(posedge clk) begin
    if (acc_read) begin
      rd_oob_r <= (slot_v >= VLimit);
    end
    if (acc_solve) begin
      count_r  <= (vc_v > VLimit) ? VLimit : vc_v;
      iter_r   <= 16'd0;
      sweeps_r <= 16'd0;
      conv_r   <= 1'b0;
    end
    if (cmd.op == wlgs_pkg::DP_SWEEP_INIT) begin
      vidx_r  <= '0;
      maxch_r <= 32'd0;
    end
    if (cmd.op == wlgs_pkg::DP_V_CHK) begin
      old_r <= val_rd_r;
      wt_r  <= meta_rd_r.wt;
      len_r <= meta_rd_r.len;
      k_r   <= 14'd0;
      e_r   <= EW'(meta_rd_r.start);
      acc_r <= 64'd0;
    end
    if ((cmd.op == wlgs_pkg::DP_E_SKIP) || (cmd.op == wlgs_pkg::DP_E_ACC)) begin
      k_r <= k_r + 14'd1;
      e_r <= e_r + EW'(1);
    end
    if (cmd.op == wlgs_pkg::DP_E_TGT) begin
      ew_r <= edge_rd_r.weight;
    end
    if (cmd.op == wlgs_pkg::DP_E_MUL) begin
      prod_r <= mul_full[63:0];
    end
    if (cmd.op == wlgs_pkg::DP_E_ACC) begin
      acc_r <= acc_sat;
    end
    // Divider: magnitude in, quotient shifts in from the bottom.
    if (cmd.op == wlgs_pkg::DP_DIV_INIT) begin
      neg_r  <= acc_r[63];
      dvd_r  <= acc_r[63] ? (64'd0 - acc_r) : acc_r;
      rem_r  <= 32'd0;
      dcnt_r <= DCW'(wlgs_pkg::DivBits);
    end
    if (cmd.op == wlgs_pkg::DP_DIV_STEP) begin
      rem_r  <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
      dvd_r  <= {dvd_r[62:0], q_bit};
      dcnt_r <= dcnt_r - DCW'(1);
    end
    if (cmd.op == wlgs_pkg::DP_V_WB) begin
      if (change > maxch_r) maxch_r <= change;
    end
    if (cmd.op == wlgs_pkg::DP_V_NEXT) begin
      vidx_r <= vidx_inc;
    end
    // End of a sweep: stop on tolerance or limit, else count on.
    if (cmd.sw_end) begin
      priority if (stat.conv_hit) begin
        sweeps_r <= iter_inc[15:0];
        conv_r   <= 1'b1;
      end else if (stat.iter_last) begin
        sweeps_r <= max_iter_r;
      end else begin
        iter_r <= iter_inc[15:0];
      end
    end
  end

  // Output register; a new result loads when it is empty or as the old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.op == wlgs_pkg::DP_OUT_RD) || (cmd.op == wlgs_pkg::DP_OUT_ST)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == wlgs_pkg::DP_OUT_RD) begin
      out_kind_r   <= wlgs_pkg::KindRead;
      out_value_r  <= rd_oob_r ? 32'd0 : val_rd_r;
      out_sweeps_r <= 16'd0;
      out_conv_r   <= 1'b0;
    end else if (cmd.op == wlgs_pkg::DP_OUT_ST) begin
      out_kind_r   <= wlgs_pkg::KindStatus;
      out_value_r  <= 32'd0;
      out_sweeps_r <= sweeps_r;
      out_conv_r   <= conv_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_result_value = out_value_r;
  assign out_sweeps_done  = out_sweeps_r;
  assign out_converged    = out_conv_r;

endmodule

`default_nettype wire
